// ----- sv/mtsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtsd_pkg
// Shared types and constants of the multi-terminal serial device: the bank
// size, register offsets, control bits, action codes and item formats.
// ----------------------------------------------------------------------------
package mtsd_pkg;

  localparam int NUM_TERMINALS = 4;
  localparam int MAX_RESULTS   = 4;
  localparam int TIDX_W        = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
  localparam int SLOT_W        = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH    = 2 * MAX_RESULTS;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int IRQ_TERMS     = (NUM_TERMINALS < 4) ? NUM_TERMINALS : 4;

  localparam logic [7:0] OFF_RX_CTRL = 8'd0;
  localparam logic [7:0] OFF_RX_DATA = 8'd8;
  localparam logic [7:0] OFF_TX_CTRL = 8'd16;
  localparam logic [7:0] OFF_TX_DATA = 8'd24;

  localparam int CTRL_READY_BIT  = 0;
  localparam int CTRL_ENABLE_BIT = 1;

  localparam logic [0:0] CFG_ACTIVE_TERMINALS = 1'b0;
  localparam logic [0:0] CFG_TRANSMIT_DELAY   = 1'b1;

  typedef enum logic [1:0] {
    ACT_READ    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RECEIVE = 2'd2,
    ACT_TICK    = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [2:0] terminal;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic       side_effects;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       trap;
    logic       tx_valid;
    logic [1:0] tx_terminal;
    logic [7:0] tx_byte;
    logic [7:0] irq_lines;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/mtsd_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtsd_core
// Terminal register bank and configuration registers. Applies one request
// per cycle while go is high and produces all of its result items at once.
// ----------------------------------------------------------------------------
module mtsd_core (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        cfg_write,
  input  wire logic [0:0]                                  cfg_index,
  input  wire logic [15:0]                                 cfg_data,
  input  wire logic                                        go,
  input  wire mtsd_pkg::item_t                             item,
  output logic [mtsd_pkg::CNT_W-1:0]                       push_cnt,
  output mtsd_pkg::result_t [mtsd_pkg::MAX_RESULTS-1:0]    push_data
);

  localparam int N = mtsd_pkg::NUM_TERMINALS;

  logic [2:0]            active_terminals;
  logic [15:0]           transmit_delay_ticks;

  logic [N-1:0]          rx_ready, rx_ready_next;
  logic [N-1:0]          rx_ien, rx_ien_next;
  logic [N-1:0][7:0]     rx_byte, rx_byte_next;
  logic [N-1:0]          tx_ready, tx_ready_next;
  logic [N-1:0]          tx_ien, tx_ien_next;
  logic [N-1:0][7:0]     tx_byte_held, tx_byte_held_next;
  logic [N-1:0][15:0]    tx_countdown, tx_countdown_next;

  logic [3:0]                       present_count;
  logic                             present;
  logic [mtsd_pkg::TIDX_W-1:0]      tidx;
  logic [15:0]                      delay_load;
  logic [mtsd_pkg::CNT_W-1:0]       n_fire;
  logic [mtsd_pkg::CNT_W-1:0]       n_res;
  logic [7:0]                       irq;
  mtsd_pkg::result_t [mtsd_pkg::MAX_RESULTS-1:0] results;

  assign present_count = ({1'b0, active_terminals} > 4'(N)) ? 4'(N)
                                                            : {1'b0, active_terminals};
  assign present    = {1'b0, item.terminal} < present_count;
  assign tidx       = item.terminal[mtsd_pkg::TIDX_W-1:0];
  assign delay_load = (transmit_delay_ticks != 16'd0) ? transmit_delay_ticks : 16'd1;

  always_comb begin
    rx_ready_next     = rx_ready;
    rx_ien_next       = rx_ien;
    rx_byte_next      = rx_byte;
    tx_ready_next     = tx_ready;
    tx_ien_next       = tx_ien;
    tx_byte_held_next = tx_byte_held;
    tx_countdown_next = tx_countdown;
    results           = '0;
    n_fire            = '0;
    n_res             = mtsd_pkg::CNT_W'(1);
    irq               = '0;

    if (go) begin
      case (item.action)
        mtsd_pkg::ACT_READ: begin
          if (!present) begin
            results[0].trap = 1'b1;
          end else begin
            case (item.reg_offset)
              mtsd_pkg::OFF_RX_CTRL: begin
                results[0].read_data = {6'd0, rx_ien[tidx], rx_ready[tidx]};
              end
              mtsd_pkg::OFF_RX_DATA: begin
                results[0].read_data = rx_byte[tidx];
                if (item.side_effects) begin
                  rx_ready_next[tidx] = 1'b0;
                end
              end
              mtsd_pkg::OFF_TX_CTRL: begin
                results[0].read_data = {6'd0, tx_ien[tidx], tx_ready[tidx]};
              end
              default: results[0].trap = 1'b1;
            endcase
          end
        end
        mtsd_pkg::ACT_WRITE: begin
          if (!present) begin
            results[0].trap = 1'b1;
          end else begin
            case (item.reg_offset)
              mtsd_pkg::OFF_RX_CTRL: begin
                rx_ready_next[tidx] = item.write_data[mtsd_pkg::CTRL_READY_BIT];
                rx_ien_next[tidx]   = item.write_data[mtsd_pkg::CTRL_ENABLE_BIT];
              end
              mtsd_pkg::OFF_TX_CTRL: begin
                tx_ready_next[tidx] = item.write_data[mtsd_pkg::CTRL_READY_BIT];
                tx_ien_next[tidx]   = item.write_data[mtsd_pkg::CTRL_ENABLE_BIT];
              end
              mtsd_pkg::OFF_TX_DATA: begin
                tx_byte_held_next[tidx] = item.write_data;
                tx_ready_next[tidx]     = 1'b0;
                tx_countdown_next[tidx] = delay_load;
              end
              default: results[0].trap = 1'b1;
            endcase
          end
        end
        mtsd_pkg::ACT_RECEIVE: begin
          // A byte for an absent terminal is dropped without a trap.
          if (present) begin
            rx_byte_next[tidx]  = item.received_byte;
            rx_ready_next[tidx] = 1'b1;
          end
        end
        mtsd_pkg::ACT_TICK: begin
          // Firing transmitters fill result slots in ascending order; any
          // beyond the slot count hold at one and fire on the next tick.
          for (int i = 0; i < N; i++) begin
            if (tx_countdown[i] > 16'd1) begin
              tx_countdown_next[i] = tx_countdown[i] - 16'd1;
            end else if (tx_countdown[i] == 16'd1 &&
                         n_fire < mtsd_pkg::CNT_W'(mtsd_pkg::MAX_RESULTS)) begin
              tx_countdown_next[i] = 16'd0;
              tx_ready_next[i]     = 1'b1;
              results[n_fire[mtsd_pkg::SLOT_W-1:0]].tx_valid    = 1'b1;
              results[n_fire[mtsd_pkg::SLOT_W-1:0]].tx_terminal = 2'(i);
              results[n_fire[mtsd_pkg::SLOT_W-1:0]].tx_byte     = tx_byte_held[i];
              n_fire = n_fire + mtsd_pkg::CNT_W'(1);
            end
          end
          if (n_fire != '0) begin
            n_res = n_fire;
          end
        end
        default: ;
      endcase
    end

    for (int i = 0; i < mtsd_pkg::IRQ_TERMS; i++) begin
      irq[2*i]   = tx_ready_next[i] & tx_ien_next[i];
      irq[2*i+1] = rx_ready_next[i] & rx_ien_next[i];
    end
    for (int k = 0; k < mtsd_pkg::MAX_RESULTS; k++) begin
      results[k].irq_lines = irq;
      results[k].last      = (mtsd_pkg::CNT_W'(k) == n_res - mtsd_pkg::CNT_W'(1));
    end
  end

  assign push_cnt  = go ? n_res : '0;
  assign push_data = results;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_terminals     <= 3'd4;
      transmit_delay_ticks <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        mtsd_pkg::CFG_ACTIVE_TERMINALS: active_terminals     <= cfg_data[2:0];
        mtsd_pkg::CFG_TRANSMIT_DELAY:   transmit_delay_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_ready     <= '0;
      rx_ien       <= '0;
      rx_byte      <= '0;
      tx_ready     <= '1;
      tx_ien       <= '0;
      tx_byte_held <= '0;
      tx_countdown <= '0;
    end else begin
      rx_ready     <= rx_ready_next;
      rx_ien       <= rx_ien_next;
      rx_byte      <= rx_byte_next;
      tx_ready     <= tx_ready_next;
      tx_ien       <= tx_ien_next;
      tx_byte_held <= tx_byte_held_next;
      tx_countdown <= tx_countdown_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mtsd_result_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtsd_result_fifo
// Result queue: takes up to a full set of result items per cycle and hands
// them out one per cycle on the output stream while the output is ready.
// ----------------------------------------------------------------------------
module mtsd_result_fifo (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic [mtsd_pkg::CNT_W-1:0]                  push_cnt,
  input  wire mtsd_pkg::result_t [mtsd_pkg::MAX_RESULTS-1:0] push_data,
  output logic                                             room,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output mtsd_pkg::result_t                                out_data
);

  mtsd_pkg::result_t              mem [mtsd_pkg::FIFO_DEPTH];
  logic [mtsd_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [mtsd_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [mtsd_pkg::FIFO_AW:0]     count;
  logic                           pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem[rd_ptr];
  // Room for a whole set of results without looking at the output side.
  assign room      = count <= (mtsd_pkg::FIFO_AW+1)'(mtsd_pkg::FIFO_DEPTH -
                                                     mtsd_pkg::MAX_RESULTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mtsd_pkg::FIFO_AW'(push_cnt);
      rd_ptr <= rd_ptr + mtsd_pkg::FIFO_AW'(pop);
      count  <= count + (mtsd_pkg::FIFO_AW+1)'(push_cnt) - (mtsd_pkg::FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mtsd_pkg::MAX_RESULTS; k++) begin
      if (mtsd_pkg::CNT_W'(k) < push_cnt) begin
        mem[wr_ptr + mtsd_pkg::FIFO_AW'(k)] <= push_data[k];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/multi_terminal_serial_device_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_terminal_serial_device_core
// Bank of memory-mapped character terminals with receive and transmit sides.
// ----------------------------------------------------------------------------
// Order: a request accepted into the input register is applied once the result
// queue has room, its results are written to the queue and offered from there.
// Throughput: one request per cycle while the result queue has room; a tick
// that sends k bytes yields k results, the result queue absorbing the burst.
// Reset clears the input register, the result queue and all terminal state.
module multi_terminal_serial_device_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // action[1:0], terminal[4:2], reg_offset[12:5], write_data[20:13],
  // side_effects[21], received_byte[29:22], zero padding[31:30]
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_data[7:0], trap[8], tx_valid[9], tx_terminal[11:10], tx_byte[19:12],
  // irq_lines[27:20], zero padding[31:28]
  output logic [31:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic                                           in_valid;
  mtsd_pkg::item_t                                in_item;
  logic                                           process;
  logic                                           room;
  logic [mtsd_pkg::CNT_W-1:0]                     push_cnt;
  mtsd_pkg::result_t [mtsd_pkg::MAX_RESULTS-1:0]  push_data;
  mtsd_pkg::result_t                              out_res;

  assign process  = in_valid & room;
  assign s_tready = ~in_valid | process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action        <= mtsd_pkg::action_t'(s_tdata[1:0]);
      in_item.terminal      <= s_tdata[4:2];
      in_item.reg_offset    <= s_tdata[12:5];
      in_item.write_data    <= s_tdata[20:13];
      in_item.side_effects  <= s_tdata[21];
      in_item.received_byte <= s_tdata[29:22];
    end
  end

  mtsd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (process),
    .item      (in_item),
    .push_cnt  (push_cnt),
    .push_data (push_data)
  );

  mtsd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {4'd0, out_res.irq_lines, out_res.tx_byte, out_res.tx_terminal,
                    out_res.tx_valid, out_res.trap, out_res.read_data};
  assign m_tlast = out_res.last;

endmodule
`default_nettype wire

// ----- sv/mtsd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtsd_checker
// Port-level checks of the terminal bank's output stream.
// ----------------------------------------------------------------------------
module mtsd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A trapped access returns no read data and sends no byte.
  a_trap_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0 && !m_tdata[9])
    else $error("trap result carries data");

  // Without a transmission, sender and character are zero.
  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] |-> m_tdata[19:10] == 10'd0)
    else $error("transmit fields set without a transmission");

  // A transmission never comes with read data.
  a_tx_no_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[7:0] == 8'd0)
    else $error("read data on a transmit result");

endmodule

bind multi_terminal_serial_device_core mtsd_checker u_mtsd_checker (.*);
`default_nettype wire

// ----- dv/tb_multi_terminal_serial_device_core.sv -----
// ----------------------------------------------------------------------------
// tb_multi_terminal_serial_device_core
// Self-checking testbench for the terminal bank. A behavioral predictor keeps
// its own copy of every terminal's receive and transmit state. For each
// accepted request it queues the responses it expects, and a monitor compares
// every response on the output stream against that queue. Directed tests
// cover register access, traps and transmit timing. Random traffic follows,
// with idle bursts on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_multi_terminal_serial_device_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_write = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Predicted terminal state and configuration.
  logic        rx_rdy   [mtsd_pkg::NUM_TERMINALS];
  logic        rx_en    [mtsd_pkg::NUM_TERMINALS];
  logic [7:0]  rx_data  [mtsd_pkg::NUM_TERMINALS];
  logic        tx_rdy   [mtsd_pkg::NUM_TERMINALS];
  logic        tx_en    [mtsd_pkg::NUM_TERMINALS];
  logic [7:0]  tx_held  [mtsd_pkg::NUM_TERMINALS];
  logic [15:0] tx_count [mtsd_pkg::NUM_TERMINALS];
  logic [2:0]  cur_active = 3'd4;
  logic [15:0] cur_delay  = 16'd1;

  mtsd_pkg::result_t expected_responses [$];
  int      mismatches     = 0;
  int      stuck_cycles   = 0;
  bit      send_gaps_en   = 1'b1;
  bit      recv_stalls_en = 1'b1;
  bit      hold_request   = 1'b0;

  multi_terminal_serial_device_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // Applies one request to the predicted state and queues its responses.
  task automatic compute_terminal_response(input mtsd_pkg::item_t req);
    mtsd_pkg::result_t batch [$];
    mtsd_pkg::result_t r;
    logic [7:0]        irq;
    int                present_n;
    bit                present;
    int                t;
    present_n = (cur_active > mtsd_pkg::NUM_TERMINALS) ? mtsd_pkg::NUM_TERMINALS
                                                       : cur_active;
    present   = req.terminal < present_n;
    t         = req.terminal;
    r         = '0;
    case (req.action)
      mtsd_pkg::ACT_READ: begin
        if (!present) begin
          r.trap = 1'b1;
        end else if (req.reg_offset == mtsd_pkg::OFF_RX_CTRL) begin
          r.read_data[mtsd_pkg::CTRL_READY_BIT]  = rx_rdy[t];
          r.read_data[mtsd_pkg::CTRL_ENABLE_BIT] = rx_en[t];
        end else if (req.reg_offset == mtsd_pkg::OFF_RX_DATA) begin
          r.read_data = rx_data[t];
          if (req.side_effects) rx_rdy[t] = 1'b0;
        end else if (req.reg_offset == mtsd_pkg::OFF_TX_CTRL) begin
          r.read_data[mtsd_pkg::CTRL_READY_BIT]  = tx_rdy[t];
          r.read_data[mtsd_pkg::CTRL_ENABLE_BIT] = tx_en[t];
        end else begin
          r.trap = 1'b1;
        end
        batch.push_back(r);
      end
      mtsd_pkg::ACT_WRITE: begin
        if (!present) begin
          r.trap = 1'b1;
        end else if (req.reg_offset == mtsd_pkg::OFF_RX_CTRL) begin
          rx_rdy[t] = req.write_data[mtsd_pkg::CTRL_READY_BIT];
          rx_en[t]  = req.write_data[mtsd_pkg::CTRL_ENABLE_BIT];
        end else if (req.reg_offset == mtsd_pkg::OFF_TX_CTRL) begin
          tx_rdy[t] = req.write_data[mtsd_pkg::CTRL_READY_BIT];
          tx_en[t]  = req.write_data[mtsd_pkg::CTRL_ENABLE_BIT];
        end else if (req.reg_offset == mtsd_pkg::OFF_TX_DATA) begin
          tx_held[t]  = req.write_data;
          tx_rdy[t]   = 1'b0;
          tx_count[t] = (cur_delay == 16'd0) ? 16'd1 : cur_delay;
        end else begin
          r.trap = 1'b1;
        end
        batch.push_back(r);
      end
      mtsd_pkg::ACT_RECEIVE: begin
        if (present) begin
          rx_data[t] = req.received_byte;
          rx_rdy[t]  = 1'b1;
        end
        batch.push_back(r);
      end
      default: begin
        for (int i = 0; i < mtsd_pkg::NUM_TERMINALS; i++) begin
          if (tx_count[i] == 16'd0) continue;
          if (tx_count[i] > 16'd1) begin
            tx_count[i] = tx_count[i] - 16'd1;
            continue;
          end
          // Transmitters beyond the per-tick limit hold at one and go next time.
          if (batch.size() >= mtsd_pkg::MAX_RESULTS) continue;
          tx_count[i]   = 16'd0;
          tx_rdy[i]     = 1'b1;
          r             = '0;
          r.tx_valid    = 1'b1;
          r.tx_terminal = 2'(i);
          r.tx_byte     = tx_held[i];
          batch.push_back(r);
        end
        if (batch.size() == 0) batch.push_back(mtsd_pkg::result_t'('0));
      end
    endcase
    irq = '0;
    for (int i = 0; i < mtsd_pkg::IRQ_TERMS; i++) begin
      irq[2*i]   = tx_rdy[i] & tx_en[i];
      irq[2*i+1] = rx_rdy[i] & rx_en[i];
    end
    foreach (batch[k]) begin
      r           = batch[k];
      r.irq_lines = irq;
      r.last      = (k == batch.size() - 1);
      expected_responses.push_back(r);
    end
  endtask

  function automatic mtsd_pkg::item_t bus_read(input logic [2:0] term,
                                               input logic [7:0] off,
                                               input logic se);
    mtsd_pkg::item_t req;
    req              = '0;
    req.action       = mtsd_pkg::ACT_READ;
    req.terminal     = term;
    req.reg_offset   = off;
    req.side_effects = se;
    return req;
  endfunction

  function automatic mtsd_pkg::item_t bus_write(input logic [2:0] term,
                                                input logic [7:0] off,
                                                input logic [7:0] data);
    mtsd_pkg::item_t req;
    req            = '0;
    req.action     = mtsd_pkg::ACT_WRITE;
    req.terminal   = term;
    req.reg_offset = off;
    req.write_data = data;
    return req;
  endfunction

  function automatic mtsd_pkg::item_t rx_char(input logic [2:0] term,
                                              input logic [7:0] ch);
    mtsd_pkg::item_t req;
    req               = '0;
    req.action        = mtsd_pkg::ACT_RECEIVE;
    req.terminal      = term;
    req.received_byte = ch;
    return req;
  endfunction

  function automatic mtsd_pkg::item_t time_tick();
    mtsd_pkg::item_t req;
    req        = '0;
    req.action = mtsd_pkg::ACT_TICK;
    return req;
  endfunction

  // Mostly valid registers on present terminals, with some noise mixed in.
  function automatic mtsd_pkg::item_t random_request();
    mtsd_pkg::item_t req;
    int              pick;
    req.terminal = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
    pick = $urandom_range(0, 19);
    req.action = (pick < 7)  ? mtsd_pkg::ACT_READ :
                 (pick < 13) ? mtsd_pkg::ACT_WRITE :
                 (pick < 16) ? mtsd_pkg::ACT_RECEIVE : mtsd_pkg::ACT_TICK;
    case ($urandom_range(0, 9))
      0:       req.reg_offset = 8'($urandom);
      1, 2:    req.reg_offset = mtsd_pkg::OFF_RX_CTRL;
      3, 4:    req.reg_offset = mtsd_pkg::OFF_RX_DATA;
      5, 6:    req.reg_offset = mtsd_pkg::OFF_TX_CTRL;
      default: req.reg_offset = mtsd_pkg::OFF_TX_DATA;
    endcase
    req.write_data    = 8'($urandom);
    req.side_effects  = 1'($urandom);
    req.received_byte = 8'($urandom);
    return req;
  endfunction

  // Called only at a rising edge. The valid stays high after acceptance so
  // that back-to-back requests need no second assignment in one step.
  task automatic send_item(input mtsd_pkg::item_t req);
    if (send_gaps_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, req.received_byte, req.side_effects, req.write_data,
                 req.reg_offset, req.terminal, req.action};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    compute_terminal_response(req);
  endtask

  task automatic wait_for_responses();
    s_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == mtsd_pkg::CFG_ACTIVE_TERMINALS) cur_active = val[2:0];
    else cur_delay = val;
    @(posedge clk);
  endtask

  task automatic test_register_access();
    send_item(bus_read(3'd0, mtsd_pkg::OFF_RX_CTRL, 1'b0));
    send_item(bus_read(3'd3, mtsd_pkg::OFF_TX_CTRL, 1'b0));
    send_item(bus_write(3'd0, mtsd_pkg::OFF_RX_CTRL, 8'hFF));
    send_item(rx_char(3'd0, 8'hFF));
    // A second character while ready overwrites the first.
    send_item(rx_char(3'd0, 8'h00));
    send_item(bus_read(3'd0, mtsd_pkg::OFF_RX_DATA, 1'b0));
    send_item(bus_read(3'd0, mtsd_pkg::OFF_RX_DATA, 1'b1));
    send_item(bus_read(3'd0, mtsd_pkg::OFF_RX_CTRL, 1'b0));
    // A character for an absent terminal is dropped without a trap.
    send_item(rx_char(3'd7, 8'hA5));
    send_item(bus_read(3'd2, mtsd_pkg::OFF_TX_DATA, 1'b1));
    send_item(bus_write(3'd2, mtsd_pkg::OFF_RX_DATA, 8'h55));
    send_item(bus_read(3'd1, 8'hFF, 1'b1));
    send_item(bus_write(3'd4, mtsd_pkg::OFF_TX_CTRL, 8'h03));
    send_item(bus_write(3'd1, mtsd_pkg::OFF_TX_CTRL, 8'h02));
    send_item(bus_write(3'd1, mtsd_pkg::OFF_TX_DATA, 8'hC3));
    send_item(time_tick());
    wait_for_responses();
  endtask

  task automatic test_transmit_timing();
    // A zero delay still waits for one tick.
    write_reg(mtsd_pkg::CFG_TRANSMIT_DELAY, 16'd0);
    send_item(bus_write(3'd2, mtsd_pkg::OFF_TX_DATA, 8'h3C));
    send_item(time_tick());
    wait_for_responses();
    // Rewriting while pending replaces the byte and restarts the countdown.
    write_reg(mtsd_pkg::CFG_TRANSMIT_DELAY, 16'd2);
    send_item(bus_write(3'd0, mtsd_pkg::OFF_TX_DATA, 8'h81));
    send_item(time_tick());
    send_item(bus_write(3'd0, mtsd_pkg::OFF_TX_DATA, 8'h7E));
    send_item(time_tick());
    send_item(time_tick());
    // All transmitters fire on the same tick.
    for (int t = 0; t < mtsd_pkg::NUM_TERMINALS; t++)
      send_item(bus_write(3'(t), mtsd_pkg::OFF_TX_DATA, 8'(8'h10 + t)));
    send_item(time_tick());
    send_item(time_tick());
    send_item(bus_write(3'd3, mtsd_pkg::OFF_TX_DATA, 8'hE7));
    wait_for_responses();
    // The countdown keeps running after the bank shrinks below its terminal.
    write_reg(mtsd_pkg::CFG_ACTIVE_TERMINALS, 16'd1);
    send_item(time_tick());
    send_item(time_tick());
    send_item(bus_read(3'd3, mtsd_pkg::OFF_TX_CTRL, 1'b0));
    wait_for_responses();
    write_reg(mtsd_pkg::CFG_ACTIVE_TERMINALS, 16'd7);
    send_item(bus_read(3'd3, mtsd_pkg::OFF_TX_CTRL, 1'b0));
    wait_for_responses();
    write_reg(mtsd_pkg::CFG_ACTIVE_TERMINALS, 16'd0);
    send_item(bus_read(3'd0, mtsd_pkg::OFF_RX_CTRL, 1'b0));
    wait_for_responses();
    write_reg(mtsd_pkg::CFG_ACTIVE_TERMINALS, 16'd4);
    write_reg(mtsd_pkg::CFG_TRANSMIT_DELAY, 16'hFFFF);
    send_item(bus_write(3'd2, mtsd_pkg::OFF_TX_DATA, 8'hFF));
    send_item(time_tick());
    wait_for_responses();
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(mtsd_pkg::CFG_ACTIVE_TERMINALS, 16'($urandom_range(1, 4)));
      write_reg(mtsd_pkg::CFG_TRANSMIT_DELAY, 16'($urandom_range(0, 4)));
      repeat (per_phase) send_item(random_request());
      wait_for_responses();
    end
  endtask

  // The output side holds off long enough for the response queue to fill and
  // the input to stall, while requests keep coming without gaps.
  task automatic test_back_pressure();
    send_gaps_en = 1'b0;
    hold_request = 1'b1;
    repeat (20) send_item(random_request());
    wait_for_responses();
    send_gaps_en = 1'b1;
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (recv_stalls_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_responses
    mtsd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_responses.size() == 0) begin
        report_mismatch("unexpected response", m_tdata, 32'd0);
      end else begin
        want = expected_responses.pop_front();
        if (m_tdata[7:0] !== want.read_data)
          report_mismatch("read_data", m_tdata[7:0], want.read_data);
        if (m_tdata[8] !== want.trap)
          report_mismatch("trap", m_tdata[8], want.trap);
        if (m_tdata[9] !== want.tx_valid)
          report_mismatch("tx_valid", m_tdata[9], want.tx_valid);
        if (m_tdata[11:10] !== want.tx_terminal)
          report_mismatch("tx_terminal", m_tdata[11:10], want.tx_terminal);
        if (m_tdata[19:12] !== want.tx_byte)
          report_mismatch("tx_byte", m_tdata[19:12], want.tx_byte);
        if (m_tdata[27:20] !== want.irq_lines)
          report_mismatch("irq_lines", m_tdata[27:20], want.irq_lines);
        if (m_tlast !== want.last)
          report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  // Counts cycles in which work is outstanding but nothing moves.
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && expected_responses.size() == 0))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < mtsd_pkg::NUM_TERMINALS; i++) begin
      rx_rdy[i]   = 1'b0;
      rx_en[i]    = 1'b0;
      rx_data[i]  = 8'd0;
      tx_rdy[i]   = 1'b1;
      tx_en[i]    = 1'b0;
      tx_held[i]  = 8'd0;
      tx_count[i] = 16'd0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_transmit_timing();
    test_random_traffic(3, 30);
    test_back_pressure();
    send_gaps_en   = 1'b0;
    recv_stalls_en = 1'b0;
    test_random_traffic(1, 30);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- multi_terminal_serial_device_core.f -----
sv/mtsd_pkg.sv
sv/mtsd_core.sv
sv/mtsd_result_fifo.sv
sv/multi_terminal_serial_device_core.sv
sv/mtsd_checker.sv
dv/tb_multi_terminal_serial_device_core.sv
